>>> hdl/pwa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page walk access package
// Shared types, codes and helpers of the two-level page walk access unit.
// ----------------------------------------------------------------------------
package pwa_pkg;

    // Input actions
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_DATA  = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_RD    = 2'd0;
    localparam logic [1:0] KIND_WR    = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_FAULT = 2'd3;

    // Fault causes
    localparam logic CAUSE_NOT_PRESENT = 1'b0;
    localparam logic CAUSE_WRITE_CROSS = 1'b1;

    // Walk phases
    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_WAIT_DIR  = 2'd1;
    localparam logic [1:0] PH_WAIT_TBL  = 2'd2;
    localparam logic [1:0] PH_WAIT_DATA = 2'd3;

    // Configuration register indexes
    localparam logic CFG_PAGING_ON = 1'b0;
    localparam logic CFG_DIR_BASE  = 1'b1;

    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 72;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] virt_addr;
        logic [2:0]  access_bytes;
        logic [31:0] write_value;
        logic [31:0] mem_word;
    } pwa_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] phys_addr;
        logic [2:0]  phys_bytes;
        logic [31:0] value;
        logic        fault_cause;
    } pwa_result_t;

    // Mask keeping the low n bytes of a word; four or more keeps all.
    function automatic logic [31:0] byte_mask(input logic [2:0] n);
        logic [31:0] m;
        case (n)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00ff;
            3'd2:    m = 32'h0000_ffff;
            3'd3:    m = 32'h00ff_ffff;
            default: m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

endpackage

>>> hdl/two_level_page_walk_access.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-level page walk access unit
// Translates virtual reads and writes through a two-level page table when
// paging is on and issues physical requests; returned data words drive the walk forward.
// ----------------------------------------------------------------------------
// Path: an accepted input item is held in the input register; its result item,
// if any, is loaded into the result register once that register is free and
// is then on the result port.
// Throughput: one input item per cycle; the input side stalls only while a
// result item waits in the result register with m_tready low.
// Reset: rst_n clears the walk to idle, paging off and directory base zero.
// ----------------------------------------------------------------------------
module two_level_page_walk_access
(
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_index,
    input  logic [19:0]                      cfg_data,
    // Input items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // virt_addr[31:0], access_bytes[34:32], write_value[66:35], mem_word[98:67]
    input  logic [pwa_pkg::IN_TDATA_W-1:0]   s_tdata,
    // action[1:0]
    input  logic [1:0]                       s_tuser,
    // Result items
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // phys_addr[31:0], phys_bytes[34:32], value[66:35], fault_cause[67]
    output logic [pwa_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // kind[1:0]
    output logic [1:0]                       m_tuser
);

    logic                 paging_on_reg;
    logic [19:0]          dir_base_reg;
    logic                 in_valid_reg;
    pwa_pkg::pwa_item_t   in_item_reg;
    logic                 out_free;
    logic                 fire;
    logic                 core_valid;
    pwa_pkg::pwa_result_t core_res;
    pwa_pkg::pwa_result_t out_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            paging_on_reg <= 1'b0;
            dir_base_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pwa_pkg::CFG_PAGING_ON: paging_on_reg <= cfg_data[0];
                pwa_pkg::CFG_DIR_BASE:  dir_base_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // The registered item moves on whenever the result register can take it.
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.action       <= s_tuser;
            in_item_reg.virt_addr    <= s_tdata[31:0];
            in_item_reg.access_bytes <= s_tdata[34:32];
            in_item_reg.write_value  <= s_tdata[66:35];
            in_item_reg.mem_word     <= s_tdata[98:67];
        end
    end

    pwa_core u_core
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .item           (in_item_reg),
        .paging_on      (paging_on_reg),
        .dir_base_frame (dir_base_reg),
        .res_valid      (core_valid),
        .res            (core_res)
    );

    pwa_out_reg u_out_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire),
        .in_valid (core_valid),
        .in_res   (core_res),
        .free     (out_free),
        .ready    (m_tready),
        .valid    (m_tvalid),
        .res      (out_res)
    );

    assign m_tuser = out_res.kind;
    assign m_tdata = {4'd0, out_res.fault_cause, out_res.value,
                      out_res.phys_bytes, out_res.phys_addr};

endmodule

>>> hdl/pwa_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page walk access core
// Holds the walk state and turns one registered item into at most one result.
// ----------------------------------------------------------------------------
module pwa_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  pwa_pkg::pwa_item_t   item,
    input  logic                 paging_on,
    input  logic [19:0]          dir_base_frame,
    output logic                 res_valid,
    output pwa_pkg::pwa_result_t res
);

    logic [1:0]  phase_reg,      phase_next;
    logic [31:0] vaddr_reg,      vaddr_next;
    logic [2:0]  bytes_reg,      bytes_next;
    logic [31:0] wdata_reg,      wdata_next;
    logic        write_reg,      write_next;
    logic        second_reg,     second_next;
    logic [2:0]  low_bytes_reg,  low_bytes_next;
    logic [31:0] low_data_reg,   low_data_next;

    always_comb
    begin
        logic [2:0]  nb;
        logic [12:0] end_off;
        logic [12:0] to_page_end;
        logic        do_begin;
        logic        do_issue;
        logic [31:0] part_va;
        logic [2:0]  part_len;
        logic [31:0] issue_pa;
        logic [31:0] cur_va;
        logic [2:0]  cur_len;
        logic [31:0] d;

        phase_next     = phase_reg;
        vaddr_next     = vaddr_reg;
        bytes_next     = bytes_reg;
        wdata_next     = wdata_reg;
        write_next     = write_reg;
        second_next    = second_reg;
        low_bytes_next = low_bytes_reg;
        low_data_next  = low_data_reg;
        res_valid      = 1'b0;
        res            = '0;
        do_begin       = 1'b0;
        do_issue       = 1'b0;
        part_va        = vaddr_reg;
        part_len       = bytes_reg;
        issue_pa       = '0;

        // Address and length of the part in flight.
        cur_va  = second_reg ? vaddr_reg + {29'd0, low_bytes_reg} : vaddr_reg;
        if (low_bytes_reg == 3'd0)
            cur_len = bytes_reg;
        else
            cur_len = second_reg ? bytes_reg - low_bytes_reg : low_bytes_reg;

        nb = item.access_bytes;
        if (nb == 3'd0)
            nb = 3'd1;
        else if (nb > 3'd4)
            nb = 3'd4;
        end_off     = {1'b0, item.virt_addr[11:0]} + {10'd0, nb} - 13'd1;
        to_page_end = 13'h1000 - {1'b0, item.virt_addr[11:0]};
        d           = item.mem_word & pwa_pkg::byte_mask(cur_len);

        unique case (item.action) inside
            pwa_pkg::ACT_READ, pwa_pkg::ACT_WRITE:
            begin
                if (phase_reg == pwa_pkg::PH_IDLE)
                begin
                    vaddr_next     = item.virt_addr;
                    bytes_next     = nb;
                    wdata_next     = item.write_value;
                    write_next     = item.action[0];
                    second_next    = 1'b0;
                    low_bytes_next = 3'd0;
                    low_data_next  = '0;
                    part_va        = item.virt_addr;
                    part_len       = nb;
                    if (end_off[12] && item.action[0])
                    begin
                        res_valid       = 1'b1;
                        res.kind        = pwa_pkg::KIND_FAULT;
                        res.fault_cause = pwa_pkg::CAUSE_WRITE_CROSS;
                    end
                    else
                    begin
                        if (end_off[12])
                        begin
                            // A read crossing a page starts with the low part.
                            low_bytes_next = to_page_end[2:0];
                            part_len       = to_page_end[2:0];
                        end
                        do_begin = 1'b1;
                    end
                end
            end
            pwa_pkg::ACT_DATA:
            begin
                unique case (phase_reg)
                    pwa_pkg::PH_WAIT_DIR:
                    begin
                        res_valid      = 1'b1;
                        res.kind       = pwa_pkg::KIND_RD;
                        res.phys_addr  = {item.mem_word[31:12], 12'd0}
                                       + {20'd0, cur_va[21:12], 2'd0};
                        res.phys_bytes = 3'd4;
                        phase_next     = pwa_pkg::PH_WAIT_TBL;
                    end
                    pwa_pkg::PH_WAIT_TBL:
                    begin
                        if (!item.mem_word[0])
                        begin
                            res_valid       = 1'b1;
                            res.kind        = pwa_pkg::KIND_FAULT;
                            res.fault_cause = pwa_pkg::CAUSE_NOT_PRESENT;
                            phase_next      = pwa_pkg::PH_IDLE;
                        end
                        else
                        begin
                            do_issue = 1'b1;
                            issue_pa = {item.mem_word[31:12], cur_va[11:0]};
                            part_len = cur_len;
                        end
                    end
                    pwa_pkg::PH_WAIT_DATA:
                    begin
                        if (low_bytes_reg != 3'd0 && !second_reg)
                        begin
                            low_data_next = d;
                            second_next   = 1'b1;
                            part_va       = vaddr_reg + {29'd0, low_bytes_reg};
                            part_len      = bytes_reg - low_bytes_reg;
                            do_begin      = 1'b1;
                        end
                        else
                        begin
                            if (low_bytes_reg != 3'd0)
                                d = (d << {low_bytes_reg[1:0], 3'd0}) | low_data_reg;
                            res_valid  = 1'b1;
                            res.kind   = pwa_pkg::KIND_DONE;
                            res.value  = d;
                            phase_next = pwa_pkg::PH_IDLE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        if (do_begin)
        begin
            if (paging_on)
            begin
                res_valid      = 1'b1;
                res.kind       = pwa_pkg::KIND_RD;
                res.phys_addr  = {dir_base_frame, 12'd0} + {20'd0, part_va[31:22], 2'd0};
                res.phys_bytes = 3'd4;
                phase_next     = pwa_pkg::PH_WAIT_DIR;
            end
            else
            begin
                do_issue = 1'b1;
                issue_pa = part_va;
            end
        end

        if (do_issue)
        begin
            res_valid     = 1'b1;
            res.phys_addr = issue_pa;
            if (write_next)
            begin
                res.kind       = pwa_pkg::KIND_WR;
                res.phys_bytes = bytes_next;
                res.value      = wdata_next & pwa_pkg::byte_mask(bytes_next);
                phase_next     = pwa_pkg::PH_IDLE;
            end
            else
            begin
                res.kind       = pwa_pkg::KIND_RD;
                res.phys_bytes = part_len;
                phase_next     = pwa_pkg::PH_WAIT_DATA;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= pwa_pkg::PH_IDLE;
            vaddr_reg     <= '0;
            bytes_reg     <= '0;
            wdata_reg     <= '0;
            write_reg     <= 1'b0;
            second_reg    <= 1'b0;
            low_bytes_reg <= '0;
            low_data_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            vaddr_reg     <= vaddr_next;
            bytes_reg     <= bytes_next;
            wdata_reg     <= wdata_next;
            write_reg     <= write_next;
            second_reg    <= second_next;
            low_bytes_reg <= low_bytes_next;
            low_data_reg  <= low_data_next;
        end
    end

endmodule

>>> hdl/pwa_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page walk access result register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module pwa_out_reg
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic                 in_valid,
    input  pwa_pkg::pwa_result_t in_res,
    output logic                 free,
    input  logic                 ready,
    output logic                 valid,
    output pwa_pkg::pwa_result_t res
);

    logic                 valid_reg;
    pwa_pkg::pwa_result_t res_reg;

    assign free  = !valid_reg || ready;
    assign valid = valid_reg;
    assign res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (free)
            valid_reg <= load && in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (free && load && in_valid)
            res_reg <= in_res;
    end

endmodule
